// ----- rtl/lidar_scan_polar_to_cartesian_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the lidar polar-to-Cartesian converter.
// Shared by the checker that is bound to the top level.
// ----------------------------------------------------------------------------
`ifndef LIDAR_SCAN_POLAR_TO_CARTESIAN_DEFINES_SVH
`define LIDAR_SCAN_POLAR_TO_CARTESIAN_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define LSPC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lspc assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define LSPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lspc assertion failed");

// Next-cycle implication that also holds across reset.
`define LSPC_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lspc assertion failed");

`endif

// ----- rtl/lspc_pkg.sv -----
// ----------------------------------------------------------------------------
// lspc_pkg
// Types, constants and the arctangent table of the polar-to-Cartesian converter.
// ----------------------------------------------------------------------------
package lspc_pkg;

    // Field widths.
    localparam int RANGE_W  = 20;
    localparam int INDEX_W  = 12;
    localparam int ANGLE_W  = 32;
    localparam int POINT_W  = 21;
    localparam int KINV_W   = 24;

    // Internal datapath widths: Q24 coordinates and the residual angle.
    localparam int XY_W     = 47;
    localparam int Z_W      = 34;
    localparam int FRAC_W   = 24;

    localparam int CORDIC_ITERS = 24;
    localparam int MAX_SAMPLES  = 4096;

    // Over-range samples are reported as one kilometre.
    localparam int MM_PER_M      = 1000;
    localparam int RANGE_OVER_MM = MM_PER_M * MM_PER_M;

    // Reciprocal of the CORDIC gain in Q24.
    localparam logic [KINV_W-1:0] KINV_Q24 = 24'd10188014;

    localparam logic signed [POINT_W-1:0] POINT_MAX = 21'sd1048575;
    localparam logic signed [POINT_W-1:0] POINT_MIN = -21'sd1048576;

    // Register map, by word index.
    typedef enum logic [1:0] {
        REG_ANGLE_START = 2'd0,
        REG_ANGLE_STEP  = 2'd1,
        REG_RANGE_MIN   = 2'd2,
        REG_RANGE_MAX   = 2'd3
    } lspc_reg_t;

    // Arctangent of 2^-i as a fraction of a full turn times 2^32.
    localparam logic [ANGLE_W-1:0] ATAN_TURN [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Payload handed from cell to cell along the rotator.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             quad;
        logic                   last;
    } lspc_cord_t;

    // Beam setup registers shared by the front end.
    typedef struct packed {
        logic [ANGLE_W-1:0] angle_start;
        logic [ANGLE_W-1:0] angle_step;
        logic [RANGE_W-1:0] range_min;
        logic [RANGE_W-1:0] range_max;
    } lspc_cfg_t;

endpackage

// ----- rtl/lspc_front.sv -----
// ----------------------------------------------------------------------------
// lspc_front
// Conditions the range, forms the beam angle and seeds the rotator.
// ----------------------------------------------------------------------------
module lspc_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lspc_pkg::lspc_cfg_t          cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lspc_pkg::RANGE_W-1:0] in_range,
    input  logic [lspc_pkg::INDEX_W-1:0] in_index,
    input  logic                         in_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output lspc_pkg::lspc_cord_t         out_data
);
    import lspc_pkg::*;

    localparam int IDX_EXT_W = 17;

    // First register: conditioned range and beam angle.
    logic                a_valid_reg;
    logic                a_valid_next;
    logic [RANGE_W-1:0]  a_range_reg;
    logic [RANGE_W-1:0]  a_range_next;
    logic [ANGLE_W-1:0]  a_angle_reg;
    logic [ANGLE_W-1:0]  a_angle_next;
    logic                a_last_reg;
    logic                a_ready;

    // Second register: scaled vector, quadrant and residual angle.
    logic                b_valid_reg;
    logic                b_valid_next;
    lspc_cord_t          b_data_reg;
    lspc_cord_t          b_data_next;
    logic                b_ready;

    logic [INDEX_W-1:0]  idx_clamped;
    logic [ANGLE_W-1:0]  quad_sum;
    logic [1:0]          quad;
    logic [ANGLE_W-1:0]  resid;
    logic [RANGE_W+KINV_W-1:0] scaled;

    // A stage takes a beat when it is empty or its successor moves on.
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Range conditioning, index clamp and beam angle.
    always_comb begin
        if ({{(IDX_EXT_W-INDEX_W){1'b0}}, in_index} >= IDX_EXT_W'(MAX_SAMPLES)) begin
            idx_clamped = INDEX_W'(MAX_SAMPLES - 1);
        end else begin
            idx_clamped = in_index;
        end
        priority if (in_range < cfg.range_min) begin
            a_range_next = '0;
        end else if (in_range > cfg.range_max) begin
            a_range_next = RANGE_W'(RANGE_OVER_MM);
        end else begin
            a_range_next = in_range;
        end
        a_angle_next = cfg.angle_start
                     + ANGLE_W'({{(ANGLE_W-INDEX_W){1'b0}}, idx_clamped} * cfg.angle_step);
        a_valid_next = a_ready ? in_valid : a_valid_reg;
    end

    // Nearest quarter turn, signed residual and the gain-corrected start vector.
    always_comb begin
        quad_sum = a_angle_reg + 32'h2000_0000;
        quad     = quad_sum[ANGLE_W-1:ANGLE_W-2];
        resid    = a_angle_reg - {quad, {(ANGLE_W-2){1'b0}}};
        scaled   = {{KINV_W{1'b0}}, a_range_reg} * {{RANGE_W{1'b0}}, KINV_Q24};
        b_data_next.x    = $signed({{(XY_W-RANGE_W-KINV_W){1'b0}}, scaled});
        b_data_next.y    = '0;
        b_data_next.z    = $signed({{(Z_W-ANGLE_W){resid[ANGLE_W-1]}}, resid});
        b_data_next.quad = quad;
        b_data_next.last = a_last_reg;
        b_valid_next     = b_ready ? a_valid_reg : b_valid_reg;
    end

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_range_reg <= a_range_next;
            a_angle_reg <= a_angle_next;
            a_last_reg  <= in_last;
        end
        if (b_ready) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

// ----- rtl/lspc_cell.sv -----
// ----------------------------------------------------------------------------
// lspc_cell
// One CORDIC rotation step with its own pipeline register.
// ----------------------------------------------------------------------------
module lspc_cell #(
    parameter int STAGE = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lspc_pkg::lspc_cord_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lspc_pkg::lspc_cord_t out_data
);
    import lspc_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN =
        $signed({{(Z_W-ANGLE_W){1'b0}}, ATAN_TURN[STAGE]});

    logic                   valid_reg;
    logic                   valid_next;
    lspc_cord_t             data_reg;
    lspc_cord_t             data_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    assign in_ready = !valid_reg || out_ready;

    // Rotate toward zero residual angle; both shifts use the old vector.
    always_comb begin
        dx = $signed(in_data.y) >>> STAGE;
        dy = $signed(in_data.x) >>> STAGE;
        data_next = in_data;
        if (!in_data.z[Z_W-1]) begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN;
        end else begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/lspc_back.sv -----
// ----------------------------------------------------------------------------
// lspc_back
// Applies the quarter turn, rounds from Q24 and saturates into the output register.
// ----------------------------------------------------------------------------
module lspc_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  lspc_pkg::lspc_cord_t                in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [lspc_pkg::POINT_W-1:0] out_x,
    output logic signed [lspc_pkg::POINT_W-1:0] out_y,
    output logic                                out_last
);
    import lspc_pkg::*;

    localparam int SUM_W = XY_W + 1;
    localparam int RND_W = SUM_W - FRAC_W;

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [POINT_W-1:0] x_reg;
    logic signed [POINT_W-1:0] x_next;
    logic signed [POINT_W-1:0] y_reg;
    logic signed [POINT_W-1:0] y_next;
    logic                      last_reg;
    logic signed [XY_W-1:0]    rx;
    logic signed [XY_W-1:0]    ry;

    // Round half up and clamp to the output range.
    function automatic logic signed [POINT_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
        logic signed [SUM_W-1:0] sum;
        logic signed [RND_W-1:0] r;
        sum = $signed({v[XY_W-1], v}) + $signed(SUM_W'(1) <<< (FRAC_W - 1));
        r   = sum[SUM_W-1:FRAC_W];
        if (r > $signed(RND_W'(POINT_MAX))) begin
            return POINT_MAX;
        end else if (r < $signed({{(RND_W-POINT_W){1'b1}}, POINT_MIN})) begin
            return POINT_MIN;
        end else begin
            return r[POINT_W-1:0];
        end
    endfunction

    assign in_ready = !valid_reg || out_ready;

    // Exact quarter-turn rotation.
    always_comb begin
        unique case (in_data.quad)
            2'd1: begin
                rx = -in_data.y;
                ry = in_data.x;
            end
            2'd2: begin
                rx = -in_data.x;
                ry = -in_data.y;
            end
            2'd3: begin
                rx = in_data.y;
                ry = -in_data.x;
            end
            default: begin
                rx = in_data.x;
                ry = in_data.y;
            end
        endcase
        x_next     = round_sat(rx);
        y_next     = round_sat(ry);
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            last_reg <= in_data.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_last  = last_reg;

endmodule

// ----- rtl/lidar_scan_polar_to_cartesian.sv -----
// ----------------------------------------------------------------------------
// lidar_scan_polar_to_cartesian
// Turns one planar lidar range sample into an (x, y) point in millimetres.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_*       in         range_mm, sample_index, scan_end (tlast)
//  m_*       out        point_x, point_y, scan_end_out (tlast)
//  APB       in/out     angle_start, angle_step, range_min, range_max
//
// One beat is accepted per cycle while s_tready is high; a sample passes through
// two front-end stages, one register per CORDIC cell (24 cells) and the output
// register. Each stage holds its beat while its successor is full and stalled,
// so bubbles close up and s_tready falls only when the whole chain is full.
// Synchronous reset clears valid flags and setup registers, range_max to all 1s.
// ----------------------------------------------------------------------------
module lidar_scan_polar_to_cartesian (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beat.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [19:0] range_mm, [31:20] sample_index
    input  logic        s_tlast,   // scan_end
    // Result beat.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [20:0] point_x, [41:21] point_y, [47:42] zero
    output logic        m_tlast,   // scan_end_out
    // Setup register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lspc_pkg::*;

    logic [ANGLE_W-1:0] angle_start_reg;
    logic [ANGLE_W-1:0] angle_step_reg;
    logic [RANGE_W-1:0] range_min_reg;
    logic [RANGE_W-1:0] range_max_reg;
    lspc_cfg_t          cfg;
    lspc_reg_t          reg_sel;
    logic               wr_en;

    logic               cord_valid [CORDIC_ITERS+1];
    logic               cord_ready [CORDIC_ITERS+1];
    lspc_cord_t         cord_data  [CORDIC_ITERS+1];

    logic signed [POINT_W-1:0] pt_x;
    logic signed [POINT_W-1:0] pt_y;

    // Register writes complete in the access cycle.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = lspc_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_start_reg <= '0;
            angle_step_reg  <= '0;
            range_min_reg   <= '0;
            range_max_reg   <= '1;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_ANGLE_START: angle_start_reg <= pwdata;
                REG_ANGLE_STEP:  angle_step_reg  <= pwdata;
                REG_RANGE_MIN:   range_min_reg   <= pwdata[RANGE_W-1:0];
                REG_RANGE_MAX:   range_max_reg   <= pwdata[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_sel)
            REG_ANGLE_START: prdata = angle_start_reg;
            REG_ANGLE_STEP:  prdata = angle_step_reg;
            REG_RANGE_MIN:   prdata = {{(32-RANGE_W){1'b0}}, range_min_reg};
            REG_RANGE_MAX:   prdata = {{(32-RANGE_W){1'b0}}, range_max_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.angle_start = angle_start_reg;
    assign cfg.angle_step  = angle_step_reg;
    assign cfg.range_min   = range_min_reg;
    assign cfg.range_max   = range_max_reg;

    // Front end: conditioning, beam angle and start vector.
    lspc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_range  (s_tdata[RANGE_W-1:0]),
        .in_index  (s_tdata[RANGE_W+INDEX_W-1:RANGE_W]),
        .in_last   (s_tlast),
        .out_valid (cord_valid[0]),
        .out_ready (cord_ready[0]),
        .out_data  (cord_data[0])
    );

    // Chain of rotation cells, one per CORDIC step.
    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cell
        lspc_cell #(
            .STAGE (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cord_valid[g]),
            .in_ready  (cord_ready[g]),
            .in_data   (cord_data[g]),
            .out_valid (cord_valid[g+1]),
            .out_ready (cord_ready[g+1]),
            .out_data  (cord_data[g+1])
        );
    end

    // Quarter turn, rounding and the output register.
    lspc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cord_valid[CORDIC_ITERS]),
        .in_ready  (cord_ready[CORDIC_ITERS]),
        .in_data   (cord_data[CORDIC_ITERS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (pt_x),
        .out_y     (pt_y),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(48-2*POINT_W){1'b0}}, pt_y, pt_x};

endmodule

// ----- rtl/lspc_checker.sv -----
// ----------------------------------------------------------------------------
// lspc_checker
// Port-level checks for the polar-to-Cartesian converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "lidar_scan_polar_to_cartesian_defines.svh"

module lspc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    import lspc_pkg::*;

    localparam logic [3:0] RMAX_ADDR = {REG_RANGE_MAX, 2'b00};

    logic rmax_sel;
    logic rmax_write;

    // The upper range limit is addressed and written.
    assign rmax_sel   = (paddr == RMAX_ADDR);
    assign rmax_write = psel && penable && pwrite && pready && rmax_sel;

    // No result beat right after a reset cycle.
    `LSPC_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // A stalled result beat holds its payload.
    `LSPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // With the sink ready every stage drains, so the input side is open.
    `LSPC_ASSERT_NOW(a_ready_flow, aclk, aresetn, m_tready, s_tready)

    // The upper range limit reads back what was written to it.
    `LSPC_ASSERT_NEXT(a_rmax_readback, aclk, aresetn, rmax_write,
        !rmax_sel || prdata == {12'd0, $past(pwdata[19:0])})

endmodule

bind lidar_scan_polar_to_cartesian lspc_checker u_checker (.*);
